### hw/rtl/lcdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdw_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic       last;
  } out_item_t;

  // One LCD byte as it waits between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       last;
  } lcd_cmd_t;

  typedef struct packed {
    logic [2:0] num_lines;
    logic       backlight_on;
    logic [7:0] backlight_mask;
    logic [7:0] rs_mask;
    logic [7:0] en_mask;
  } lcdw_cfg_t;

  localparam logic [2:0] CFG_NUM_LINES      = 3'd0;
  localparam logic [2:0] CFG_BACKLIGHT_ON   = 3'd1;
  localparam logic [2:0] CFG_BACKLIGHT_MASK = 3'd2;
  localparam logic [2:0] CFG_RS_MASK        = 3'd3;
  localparam logic [2:0] CFG_EN_MASK        = 3'd4;

  localparam logic       OP_CHAR = 1'b0;

  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  localparam int QDEPTH = 4;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d > 4'd9) r = 8'h37 + {4'h0, d};
    else          r = 8'h30 + {4'h0, d};
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcdw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdw_front
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire lcdw_cfg_t cfg,
  output logic          push_valid,
  input  wire logic     push_ready,
  output lcd_cmd_t      push_data
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic             busy;
  logic             is_addr;
  logic [7:0]       cur_char;
  logic             second_pending;
  logic [7:0]       second_char;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic             is_crlf;
  logic             step_done;
  logic             finishing;
  logic             accept;
  logic [COL_W:0]   col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [2:0]       lines;
  logic [2:0]       row_ext;
  logic [2:0]       row_sel;
  logic [7:0]       addr;

  always_comb begin
    is_crlf   = (cur_char == CHAR_LF) || (cur_char == CHAR_CR);
    col_inc   = {1'b0, col} + 1'b1;
    row_inc   = (row == ROW_W'(ROWS - 1)) ? '0 : row + 1'b1;
    lines     = (cfg.num_lines == 3'd0) ? 3'd1 : cfg.num_lines;
    row_ext   = 3'(row);
    // clamp rows beyond the configured line count to its last line
    row_sel   = (row_ext >= lines) ? lines - 3'd1 : row_ext;
    addr      = 8'(col) + ROW_BASE[row_sel[1:0]];

    push_valid = busy && (is_addr || !is_crlf);
    if (is_addr) begin
      push_data = '{data: CMD_SET_DDRAM | addr, rs: 1'b0, last: !second_pending};
    end else begin
      push_data = '{data: cur_char, rs: 1'b1, last: 1'b0};
    end

    step_done = busy && (!push_valid || push_ready);
    finishing = busy && is_addr && !second_pending && push_ready;
    in_ready  = !busy || finishing;
    accept    = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      is_addr        <= 1'b0;
      second_pending <= 1'b0;
      col            <= '0;
      row            <= '0;
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        is_addr <= 1'b0;
        if (in_data.operation == OP_CHAR) begin
          cur_char       <= in_data.value;
          second_pending <= 1'b0;
        end else begin
          cur_char       <= hex_digit(in_data.value[7:4]);
          second_char    <= hex_digit(in_data.value[3:0]);
          second_pending <= 1'b1;
        end
      end else if (step_done) begin
        if (!is_addr) begin
          is_addr <= 1'b1;
          // advance the cursor before the address command is built
          if (is_crlf || (col_inc >= (COL_W + 1)'(COLUMNS))) begin
            col <= '0;
            row <= row_inc;
          end else begin
            col <= col_inc[COL_W-1:0];
          end
        end else if (second_pending) begin
          cur_char       <= second_char;
          second_pending <= 1'b0;
          is_addr        <= 1'b0;
        end else begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcdw_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdw_fifo
  import lcdw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire lcd_cmd_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output lcd_cmd_t      pop_data
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  lcd_cmd_t         mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    push_ready = (count != CNT_W'(QDEPTH));
    pop_valid  = (count != '0);
    pop_data   = mem[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcdw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdw_back
  import lcdw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire lcd_cmd_t  pop_data,
  input  wire lcdw_cfg_t cfg,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [1:0] {
    STB_PLAIN,
    STB_EN_SET,
    STB_EN_CLR
  } strobe_t;

  lcd_cmd_t   cmd;
  logic       cmd_valid;
  logic       half;
  strobe_t    stb;

  logic       emit;
  logic       fin;
  logic [3:0] nib;
  logic [7:0] base;
  logic [7:0] bl;
  logic [7:0] port_byte;

  always_comb begin
    emit      = cmd_valid && (!out_valid || out_ready);
    fin       = emit && half && (stb == STB_EN_CLR);
    pop_ready = !cmd_valid || fin;

    nib  = half ? cmd.data[3:0] : cmd.data[7:4];
    base = {nib, 4'h0} | (cmd.rs ? cfg.rs_mask : 8'h00);
    bl   = cfg.backlight_on ? cfg.backlight_mask : 8'h00;
    case (stb)
      STB_PLAIN:  port_byte = base | bl;
      STB_EN_SET: port_byte = base | cfg.en_mask | bl;
      STB_EN_CLR: port_byte = (base & ~cfg.en_mask) | bl;
      default:    port_byte = base | bl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
      half      <= 1'b0;
      stb       <= STB_PLAIN;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= '{expander_byte: port_byte, last: cmd.last && fin};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (pop_valid && pop_ready) begin
        cmd       <= pop_data;
        cmd_valid <= 1'b1;
        half      <= 1'b0;
        stb       <= STB_PLAIN;
      end else if (emit) begin
        if (fin) cmd_valid <= 1'b0;
        case (stb)
          STB_PLAIN:  stb <= STB_EN_SET;
          STB_EN_SET: stb <= STB_EN_CLR;
          STB_EN_CLR: begin
            stb  <= STB_PLAIN;
            half <= !half;
          end
          default:    stb <= STB_PLAIN;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/char_lcd_expander_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Character LCD writer for a 4-bit panel behind an 8-bit port expander.
// Input channel (in_valid/in_ready/in_data): one item is a character, or a
// byte to be shown as two uppercase hex digits. Output channel
// (out_valid/out_ready/out_data): one expander port byte per item, with
// last set on the final byte belonging to an input item.
// A shown character gives 12 port bytes (data byte then set-address
// command, each as two nibbles of three strobe bytes), CR or LF gives 6,
// a hex byte gives 24. The back end emits one port byte per cycle while the
// queue holds bytes and the receiver is ready. Into an idle block the first
// byte passes the front-end state, the queue, the command register and the
// output register; CR or LF first takes an extra front-end step.
// The front end tracks the cursor and queues LCD bytes in a four-entry
// queue; it takes the next item while the back end still streams bytes.
// When the receiver stalls, the output register holds its byte and the queue
// fills, after which in_ready drops. Reset puts the cursor at column 0, row
// 0 and loads the register defaults: 4 lines, backlight on, backlight mask
// 0x08, RS mask 0x01, enable mask 0x04. The user must write configuration
// (cfg_we/cfg_index/cfg_wdata) only while idle; the block doesn't enforce it.
module char_lcd_expander_writer
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  lcdw_cfg_t cfg;
  logic      push_valid;
  logic      push_ready;
  lcd_cmd_t  push_data;
  logic      pop_valid;
  logic      pop_ready;
  lcd_cmd_t  pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_lines      <= 3'd4;
      cfg.backlight_on   <= 1'b1;
      cfg.backlight_mask <= 8'h08;
      cfg.rs_mask        <= 8'h01;
      cfg.en_mask        <= 8'h04;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_LINES:      cfg.num_lines      <= cfg_wdata[2:0];
        CFG_BACKLIGHT_ON:   cfg.backlight_on   <= cfg_wdata[0];
        CFG_BACKLIGHT_MASK: cfg.backlight_mask <= cfg_wdata;
        CFG_RS_MASK:        cfg.rs_mask        <= cfg_wdata;
        CFG_EN_MASK:        cfg.en_mask        <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  lcdw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  lcdw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  lcdw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .cfg      (cfg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // the closing LCD byte of an item is always a set-address command
  a_last_is_cmd: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_data.last |-> !push_data.rs)
    else $error("last LCD byte queued with register select set");

  // a character other than LF or CR is offered to the queue right after acceptance
  a_char_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.operation == OP_CHAR) &&
    (in_data.value != CHAR_LF) && (in_data.value != CHAR_CR) |=> push_valid)
    else $error("accepted character not offered to the queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !pop_valid)
    else $error("output or queue not empty after reset");

endmodule

`default_nettype wire

### bench/lcd_byte_checker.sv
`timescale 1ns / 1ps

module lcd_byte_checker
  import lcdw_pkg::*;
#(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         outstanding
);

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  lcdw_cfg_t regs;
  int        col;
  int        row;
  int        err_count = 0;
  out_item_t port_bytes_due[$];
  out_item_t got;
  out_item_t want;

  task automatic queue_port_byte(input logic [7:0] b);
    out_item_t e;
    e.expander_byte = b;
    e.last          = 1'b0;
    port_bytes_due.push_back(e);
  endtask

  // plain, then enable set, then enable clear, each with the backlight bits ORed in
  task automatic queue_nibble(input logic [7:0] v);
    logic [7:0] bl;
    bl = regs.backlight_on ? regs.backlight_mask : 8'h00;
    queue_port_byte(v | bl);
    queue_port_byte(v | regs.en_mask | bl);
    queue_port_byte((v & ~regs.en_mask) | bl);
  endtask

  task automatic queue_lcd_byte(input logic [7:0] v, input logic [7:0] mode);
    queue_nibble({v[7:4], 4'h0} | mode);
    queue_nibble({v[3:0], 4'h0} | mode);
  endtask

  task automatic next_line();
    col = 0;
    row = row + 1;
    if (row >= ROWS) row = 0;
  endtask

  task automatic show_char(input logic [7:0] c);
    int         lines;
    int         addr_row;
    logic [7:0] addr;
    if (c == CHAR_LF || c == CHAR_CR) begin
      next_line();
    end else begin
      queue_lcd_byte(c, regs.rs_mask);
      col = col + 1;
      if (col >= COLUMNS) next_line();
    end
    // rows past the configured line count land on the last line
    lines    = (regs.num_lines == 3'd0) ? 1 : int'(regs.num_lines);
    addr_row = (row >= lines) ? lines - 1 : row;
    addr     = 8'(col) + ROW_BASE[addr_row % 4];
    queue_lcd_byte(CMD_SET_DDRAM | addr, 8'h00);
  endtask

  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    if (d > 4'd9) return ASCII_UPPER_A + 8'(d) - 8'd10;
    return ASCII_ZERO + 8'(d);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.num_lines      = 3'd4;
      regs.backlight_on   = 1'b1;
      regs.backlight_mask = 8'h08;
      regs.rs_mask        = 8'h01;
      regs.en_mask        = 8'h04;
      col = 0;
      row = 0;
      port_bytes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_LINES:      regs.num_lines      = cfg_wdata[2:0];
          CFG_BACKLIGHT_ON:   regs.backlight_on   = cfg_wdata[0];
          CFG_BACKLIGHT_MASK: regs.backlight_mask = cfg_wdata;
          CFG_RS_MASK:        regs.rs_mask        = cfg_wdata;
          CFG_EN_MASK:        regs.en_mask        = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (port_bytes_due.size() == 0) begin
          err_count++;
          $display("%0t: port byte expected none, got %h last %b",
                   $time, got.expander_byte, got.last);
        end else begin
          want = port_bytes_due.pop_front();
          if (got.expander_byte !== want.expander_byte) begin
            err_count++;
            $display("%0t: expander byte expected %h, got %h",
                     $time, want.expander_byte, got.expander_byte);
          end
          if (got.last !== want.last) begin
            err_count++;
            $display("%0t: last expected %b, got %b", $time, want.last, got.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_CHAR) begin
          show_char(in_data.value);
        end else begin
          show_char(hex_glyph(in_data.value[7:4]));
          show_char(hex_glyph(in_data.value[3:0]));
        end
        // mark the closing byte of this item
        want = port_bytes_due.pop_back();
        want.last = 1'b1;
        port_bytes_due.push_back(want);
      end
    end
    mismatches  <= err_count;
    outstanding <= port_bytes_due.size();
  end

endmodule

### bench/char_lcd_expander_writer_test.sv
`timescale 1ns / 1ps

module char_lcd_expander_writer_test;
  import lcdw_pkg::*;

  localparam logic OP_HEX            = 1'b1;
  localparam int   STALL_PCT         = 17;
  localparam int   RANDOM_PER_PHASE  = 40;
  localparam int   LINE_RUN          = 24;
  localparam int   IDLE_LIMIT        = 2000;
  localparam int   SETTLE_CYCLES     = 8;
  localparam int   NUM_PHASES        = 7;
  localparam int   NUM_DIRECTED      = 22;

  // {operation, value}
  localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
    {OP_CHAR, 8'h41}, {OP_CHAR, 8'h00}, {OP_CHAR, 8'hFF}, {OP_CHAR, CHAR_LF},
    {OP_CHAR, CHAR_CR}, {OP_CHAR, CHAR_CR}, {OP_CHAR, 8'h01}, {OP_CHAR, 8'h7F},
    {OP_CHAR, 8'h80}, {OP_CHAR, 8'h09}, {OP_CHAR, 8'h0B}, {OP_CHAR, 8'h0C},
    {OP_CHAR, 8'h0E}, {OP_CHAR, 8'h55}, {OP_CHAR, 8'hAA}, {OP_HEX, 8'h00},
    {OP_HEX, 8'hFF}, {OP_HEX, 8'h09}, {OP_HEX, 8'hA0}, {OP_HEX, 8'h0A},
    {OP_HEX, 8'hD3}, {OP_CHAR, CHAR_LF}
  };

  // settings per phase; the last phase draws its own
  localparam int         SET_LINES   [NUM_PHASES] = '{4, 1, 0, 7, 2, 3, 4};
  localparam logic       SET_BL_ON   [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1,
                                                     1'b1, 1'b0, 1'b1};
  localparam logic [7:0] SET_BL_MASK [NUM_PHASES] = '{8'h08, 8'hFF, 8'hFF, 8'h0C,
                                                     8'h00, 8'h55, 8'h08};
  localparam logic [7:0] SET_RS_MASK [NUM_PHASES] = '{8'h01, 8'h00, 8'hFF, 8'h02,
                                                     8'hF0, 8'hAA, 8'h01};
  localparam logic [7:0] SET_EN_MASK [NUM_PHASES] = '{8'h04, 8'hFF, 8'hFF, 8'h04,
                                                     8'h0F, 8'h80, 8'h04};

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       steady    = 1'b0;
  int         mismatches;
  int         outstanding;
  int         idle_cycles = 0;

  always #5 clk = ~clk;

  char_lcd_expander_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcd_byte_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] v);
    in_item_t it;
    it.operation = op;
    it.value     = v;
    if (!steady) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) send_item(OP_HEX, 8'($urandom));
    else if (pick < 32) send_item(OP_CHAR, $urandom_range(1) ? CHAR_LF : CHAR_CR);
    else if (pick < 62) send_item(OP_CHAR, 8'($urandom_range(8'h7E, 8'h20)));
    else send_item(OP_CHAR, 8'($urandom));
  endtask

  // drop valid and wait for the output stream to run dry
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic load_settings(input int lines, input logic bl_on,
                               input logic [7:0] bl_mask, input logic [7:0] rs,
                               input logic [7:0] en);
    write_reg(CFG_NUM_LINES, 8'(lines));
    write_reg(CFG_BACKLIGHT_ON, {7'd0, bl_on});
    write_reg(CFG_BACKLIGHT_MASK, bl_mask);
    write_reg(CFG_RS_MASK, rs);
    write_reg(CFG_EN_MASK, en);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) drain(SETTLE_CYCLES);
      if (phase == NUM_PHASES - 1) begin
        load_settings($urandom_range(7, 1), 1'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
      end else begin
        load_settings(SET_LINES[phase], SET_BL_ON[phase], SET_BL_MASK[phase],
                      SET_RS_MASK[phase], SET_EN_MASK[phase]);
      end
      steady <= (phase == 2);
      if (phase == 0) begin
        for (int i = 0; i < NUM_DIRECTED; i++) send_item(DIRECTED[i][8], DIRECTED[i][7:0]);
      end
      // long printable runs push the cursor past the last column into the next row
      if (phase % 2 == 1) begin
        repeat (LINE_RUN) send_item(OP_CHAR, 8'($urandom_range(8'h7E, 8'h20)));
      end
      repeat (RANDOM_PER_PHASE) send_random_item();
    end
    drain(3 * SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lcdw_pkg.sv
hw/rtl/lcdw_front.sv
hw/rtl/lcdw_fifo.sv
hw/rtl/lcdw_back.sv
hw/rtl/char_lcd_expander_writer.sv
bench/lcd_byte_checker.sv
bench/char_lcd_expander_writer_test.sv
